@@ sv/sha_pkg.sv @@
// Shared types, constants and tables for the SHA-256 byte-stream hasher.
`default_nettype none

package sha_pkg;

    localparam int HASH_WORDS  = 8;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 64;

    localparam logic [31:0] H_INIT [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Hash word store access: one read and one write port.
    typedef struct packed {
        logic        rd_en;
        logic [2:0]  rd_addr;
        logic        wr_en;
        logic [2:0]  wr_addr;
        logic [31:0] wr_data;
    } t_hs_req;

    // Round core control.
    typedef struct packed {
        logic       w_load;
        logic       v_load;
        logic       rnd;
        logic [2:0] v_idx;
        logic [5:0] k_idx;
    } t_core_ctl;

endpackage

`default_nettype wire

@@ sv/sha_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/sha_hstore.sv @@
// Hash word store: RAM plus per-word valid bits that stand in for the initial values.
`default_nettype none

module sha_hstore (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clear,
    input  wire sha_pkg::t_hs_req i_req,
    output logic [31:0]           o_rd_data
);
    import sha_pkg::*;

    logic [HASH_WORDS-1:0] r_valid;
    logic                  r_q_vld;
    logic [2:0]            r_q_idx;
    logic [31:0]           ram_q;

    sha_ram #(
        .WIDTH (32),
        .DEPTH (HASH_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr_en),
        .i_waddr (i_req.wr_addr),
        .i_wdata (i_req.wr_data),
        .i_re    (i_req.rd_en),
        .i_raddr (i_req.rd_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // Track whether the word being read had been written yet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
            r_q_idx <= '0;
        end else if (i_req.rd_en) begin
            r_q_vld <= r_valid[i_req.rd_addr];
            r_q_idx <= i_req.rd_addr;
        end
    end

    assign o_rd_data = r_q_vld ? ram_q : H_INIT[r_q_idx];

endmodule

`default_nettype wire

@@ sv/sha_core.sv @@
// Round core: rolling message schedule and working variables, one round per cycle.
`default_nettype none

module sha_core (
    input  wire logic               i_clk,
    input  wire sha_pkg::t_core_ctl i_ctl,
    input  wire logic [31:0]        i_w_in,
    input  wire logic [31:0]        i_h_in,
    output logic [31:0]             o_v_sel
);
    import sha_pkg::*;

    logic [31:0] r_w [BLOCK_WORDS];
    logic [31:0] r_v [HASH_WORDS];

    logic [31:0] w_new;
    logic [31:0] s0_sig;
    logic [31:0] s1_sig;
    logic [31:0] big_s0;
    logic [31:0] big_s1;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;

    function automatic logic [31:0] f_rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb begin
        s0_sig = f_rotr(r_w[1], 7) ^ f_rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1_sig = f_rotr(r_w[14], 17) ^ f_rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new  = r_w[0] + s0_sig + r_w[9] + s1_sig;

        big_s1 = f_rotr(r_v[4], 6) ^ f_rotr(r_v[4], 11) ^ f_rotr(r_v[4], 25);
        ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1     = r_v[7] + big_s1 + ch + ROUND_K[i_ctl.k_idx] + r_w[0];
        big_s0 = f_rotr(r_v[0], 2) ^ f_rotr(r_v[0], 13) ^ f_rotr(r_v[0], 22);
        maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2     = big_s0 + maj;
    end

    // Slot 0 always holds the word for the current round.
    always_ff @(posedge i_clk) begin
        if (i_ctl.w_load || i_ctl.rnd) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[BLOCK_WORDS - 1] <= i_ctl.w_load ? i_w_in : w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.v_load) begin
            r_v[i_ctl.v_idx] <= i_h_in;
        end else if (i_ctl.rnd) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_v_sel = r_v[i_ctl.v_idx];

endmodule

`default_nettype wire

@@ sv/sha256_byte_stream_hasher_top.sv @@
// Top level of the SHA-256 byte-stream hasher: byte packing, padding and sequencing.
//
//  port group   dir  tdata             tuser           tlast
//  s_axis       in   [7:0] data_byte   has_byte        end_of_message
//  m_axis       out  [31:0] digest     [2:0] word_idx  last_word
//
//  Byte beats are accepted while the block is idle; every 64th byte starts a
//  compression (schedule load, 64 rounds, hash update) with s_axis stalled.
//  The final beat pads at one word per cycle (one or two blocks), then each
//  digest word is read from the hash store and held until m_axis takes it.
//  Reset (i_rst_n low, synchronous) returns the block to the initial hash
//  values with an empty buffer; the same happens after the eighth digest beat.
`default_nettype none

module sha256_byte_stream_hasher_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tuser,   // [0] has_byte
    input  wire logic        i_s_axis_tlast,   // end_of_message
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       o_m_axis_tuser,   // [2:0] word_index
    output logic             o_m_axis_tlast    // last_word
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_UPD,
        S_ORD,
        S_OSHOW
    } t_state;

    t_state      r_state;
    logic [5:0]  r_cnt;
    logic [5:0]  r_fill;
    logic [23:0] r_word;
    logic [63:0] r_bitlen;
    logic [3:0]  r_wi;
    logic        r_marked;
    logic        r_len_ok;
    logic        r_len_done;
    logic        r_pad_mode;
    logic [2:0]  r_oidx;

    logic        s_acc;
    logic        m_acc;
    logic [5:0]  n_fill;
    logic [5:0]  cnt_m1;
    logic        mark_fits;
    logic [31:0] pad_word;

    logic        buf_we;
    logic [3:0]  buf_waddr;
    logic [31:0] buf_wdata;
    logic        buf_re;
    logic [31:0] buf_q;

    t_hs_req     hs_req;
    logic        hs_clear;
    logic [31:0] h_rd;

    t_core_ctl   core_ctl;
    logic [31:0] v_sel;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OSHOW);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc           = o_m_axis_tvalid && i_m_axis_tready;
    assign n_fill          = r_fill + 6'd1;
    assign cnt_m1          = r_cnt - 6'd1;
    assign mark_fits       = (r_wi <= 4'd13);

    // Padding word: the marker byte after the bytes already collected, then zeros and the bit length.
    always_comb begin
        pad_word = 32'h0;
        if (!r_marked) begin
            case (r_fill[1:0])
                2'd0:    pad_word = 32'h8000_0000;
                2'd1:    pad_word = {r_word[7:0], 8'h80, 16'h0};
                2'd2:    pad_word = {r_word[15:0], 8'h80, 8'h0};
                default: pad_word = {r_word[23:0], 8'h80};
            endcase
        end else if (r_len_ok && r_wi == 4'd14) begin
            pad_word = r_bitlen[63:32];
        end else if (r_len_ok && r_wi == 4'd15) begin
            pad_word = r_bitlen[31:0];
        end
    end

    always_comb begin
        buf_we    = 1'b0;
        buf_waddr = r_fill[5:2];
        buf_wdata = {r_word, i_s_axis_tdata};
        if (r_state == S_PAD) begin
            buf_we    = 1'b1;
            buf_waddr = r_wi;
            buf_wdata = pad_word;
        end else if (s_acc && i_s_axis_tuser && r_fill[1:0] == 2'd3) begin
            buf_we = 1'b1;
        end
    end

    assign buf_re = (r_state == S_LOAD) && (r_cnt[5:4] == 2'd0);

    sha_ram #(
        .WIDTH (32),
        .DEPTH (BLOCK_WORDS)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_re    (buf_re),
        .i_raddr (r_cnt[3:0]),
        .o_rdata (buf_q)
    );

    always_comb begin
        hs_req         = '0;
        hs_req.rd_addr = r_cnt[2:0];
        hs_req.wr_addr = cnt_m1[2:0];
        hs_req.wr_data = h_rd + v_sel;
        unique case (r_state)
            S_LOAD: begin
                hs_req.rd_en = (r_cnt < 6'd8);
            end
            S_UPD: begin
                hs_req.rd_en = (r_cnt < 6'd8);
                hs_req.wr_en = (r_cnt != 6'd0);
            end
            S_ORD: begin
                hs_req.rd_en   = 1'b1;
                hs_req.rd_addr = r_oidx;
            end
            default: begin
                hs_req.rd_en = 1'b0;
            end
        endcase
    end

    assign hs_clear = m_acc && (r_oidx == 3'd7);

    sha_hstore u_hstore (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (hs_clear),
        .i_req     (hs_req),
        .o_rd_data (h_rd)
    );

    always_comb begin
        core_ctl.w_load = (r_state == S_LOAD) && (r_cnt != 6'd0);
        core_ctl.v_load = (r_state == S_LOAD) && (r_cnt != 6'd0) && (r_cnt <= 6'd8);
        core_ctl.rnd    = (r_state == S_ROUND);
        core_ctl.v_idx  = cnt_m1[2:0];
        core_ctl.k_idx  = r_cnt;
    end

    sha_core u_core (
        .i_clk   (i_clk),
        .i_ctl   (core_ctl),
        .i_w_in  (buf_q),
        .i_h_in  (h_rd),
        .o_v_sel (v_sel)
    );

    // Hold the partial word until its fourth byte arrives.
    always_ff @(posedge i_clk) begin
        if (s_acc && i_s_axis_tuser) begin
            r_word <= {r_word[15:0], i_s_axis_tdata};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_fill     <= '0;
            r_bitlen   <= '0;
            r_wi       <= '0;
            r_marked   <= 1'b0;
            r_len_ok   <= 1'b0;
            r_len_done <= 1'b0;
            r_pad_mode <= 1'b0;
            r_oidx     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_marked   <= 1'b0;
                        r_len_done <= 1'b0;
                        r_pad_mode <= i_s_axis_tlast;
                        if (i_s_axis_tuser) begin
                            r_fill   <= n_fill;
                            r_bitlen <= r_bitlen + 64'd8;
                            r_wi     <= n_fill[5:2];
                            if (r_fill == 6'd63) begin
                                r_state <= S_LOAD;
                                r_cnt   <= '0;
                            end else if (i_s_axis_tlast) begin
                                r_state <= S_PAD;
                            end
                        end else if (i_s_axis_tlast) begin
                            r_wi    <= r_fill[5:2];
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (!r_marked) begin
                        r_marked <= 1'b1;
                        r_len_ok <= mark_fits;
                    end
                    if (r_wi == 4'd15) begin
                        r_len_done <= r_marked ? r_len_ok : mark_fits;
                        r_state    <= S_LOAD;
                        r_cnt      <= '0;
                    end else begin
                        r_wi <= r_wi + 4'd1;
                    end
                end
                S_LOAD: begin
                    if (r_cnt == 6'd16) begin
                        r_state <= S_ROUND;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_ROUND: begin
                    if (r_cnt == 6'd63) begin
                        r_state <= S_UPD;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_UPD: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd8) begin
                        if (!r_pad_mode) begin
                            r_state <= S_IDLE;
                        end else if (r_len_done) begin
                            r_state <= S_ORD;
                            r_oidx  <= '0;
                        end else begin
                            // Extra padding block: the marker if not yet placed, zeros, then the length.
                            r_state  <= S_PAD;
                            r_wi     <= '0;
                            r_len_ok <= 1'b1;
                        end
                    end
                end
                S_ORD: begin
                    r_state <= S_OSHOW;
                end
                S_OSHOW: begin
                    if (m_acc) begin
                        if (r_oidx == 3'd7) begin
                            r_state    <= S_IDLE;
                            r_fill     <= '0;
                            r_bitlen   <= '0;
                            r_pad_mode <= 1'b0;
                            r_len_done <= 1'b0;
                        end else begin
                            r_oidx  <= r_oidx + 3'd1;
                            r_state <= S_ORD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tdata = h_rd;
    assign o_m_axis_tuser = r_oidx;
    assign o_m_axis_tlast = (r_oidx == 3'd7);

    a_buf_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(buf_we && buf_re))
        else $error("block buffer written and read in the same cycle");

    a_upd_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_cnt != 6'd0) |-> ($past(hs_req.rd_addr) == hs_req.wr_addr))
        else $error("hash update writes a word other than the one read");

    a_round_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_ROUND) |-> ($past(r_cnt) == 6'd16))
        else $error("rounds started before the schedule was loaded");

    a_digest_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hs_clear |=> (r_state == S_IDLE && r_fill == 6'd0 && r_bitlen == 64'd0))
        else $error("state not cleared after the last digest beat");

endmodule

`default_nettype wire
